// File: design/ami_pkg.sv
// Shared types, widths and index tables for the affine matrix inverse.
// No dependencies; every other file in the design imports this package.
package ami_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int N_ELEM     = 12;
  localparam int N_LIN      = 9;
  localparam int N_AXIS     = 3;
  localparam int N_PROD     = 2 * N_LIN;

  localparam int PROD_W = 2 * DATA_WIDTH;          // element product
  localparam int COF_W  = PROD_W + 1;              // cofactor, exact
  localparam int HI_W   = COF_W - DATA_WIDTH;      // upper slice of a cofactor
  localparam int PART_W = DATA_WIDTH + HI_W;       // partial product
  localparam int DET_W  = DATA_WIDTH + COF_W;      // determinant and translation sums
  localparam int ABS_W  = DET_W - 1;               // magnitudes
  localparam int DEN_W  = ABS_W + 1;               // twice the divisor magnitude
  localparam int LIN_SH = 2 * FRAC_BITS + 1;
  localparam int TR_SH  = FRAC_BITS + 1;
  localparam int NUM_W  = ABS_W + TR_SH + 1;       // rounded dividend

  localparam int ADJ_STAGES = 6;
  localparam int DIV_STAGES = DATA_WIDTH + 4;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [COF_W-1:0]      cof_t;
  typedef logic signed [PART_W-1:0]     part_t;
  typedef logic signed [DET_W-1:0]      det_t;
  typedef logic        [ABS_W-1:0]      abs_t;
  typedef logic        [DEN_W-1:0]      den_t;
  typedef logic        [NUM_W-1:0]      num_t;

  localparam elem_t POS_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam elem_t NEG_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef struct packed {
    elem_t elem_0;
    elem_t elem_1;
    elem_t elem_2;
    elem_t elem_3;
    elem_t elem_4;
    elem_t elem_5;
    elem_t elem_6;
    elem_t elem_7;
    elem_t elem_8;
    elem_t elem_9;
    elem_t elem_10;
    elem_t elem_11;
  } in_word_t;

  typedef struct packed {
    elem_t res_0;
    elem_t res_1;
    elem_t res_2;
    elem_t res_3;
    elem_t res_4;
    elem_t res_5;
    elem_t res_6;
    elem_t res_7;
    elem_t res_8;
    elem_t res_9;
    elem_t res_10;
    elem_t res_11;
  } out_word_t;

  // Adjugate stage hands this to the divider.
  typedef struct packed {
    logic                     mode;
    elem_t [N_AXIS-1:0]       tr;
    cof_t  [N_LIN-1:0]        cof;
    det_t                     det;
    det_t  [N_AXIS-1:0]       acc;
  } adj_word_t;

  // Cofactor k is PROD_L[2k]*PROD_R[2k] - PROD_L[2k+1]*PROD_R[2k+1].
  localparam int PROD_L [N_PROD] = '{4, 7, 2, 1, 1, 2, 5, 3, 0, 2, 3, 0, 3, 6, 6, 0, 0, 3};
  localparam int PROD_R [N_PROD] = '{8, 5, 7, 8, 5, 4, 6, 8, 8, 6, 2, 5, 7, 4, 1, 7, 4, 1};

  // Cofactors that pair with elements 0..2 in the determinant.
  localparam int DET_COF [N_AXIS] = '{0, 3, 6};

  // Source cofactor of each result element in transposed mode.
  localparam int TRANS_SRC [N_LIN] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

endpackage

// File: design/ami_if.sv
// Valid/ready channel interfaces for matrix words in and result words out.
// Depends on ami_pkg.
interface ami_in_if;
  import ami_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ami_out_if;
  import ami_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/ami_adj.sv
// Six-stage pipeline: element products, cofactors, determinant and
// translation sums with split 32-bit partial products. Depends on ami_pkg.
module ami_adj (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  ami_pkg::elem_t [ami_pkg::N_ELEM-1:0]  in_elem_i,
  input  logic                                  in_mode_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output ami_pkg::adj_word_t                    out_word_o
);
  import ami_pkg::*;

  logic [ADJ_STAGES-1:0] v_q;
  logic [ADJ_STAGES:0]   rdy;

  assign rdy[ADJ_STAGES] = out_ready_i;
  for (genvar s = 0; s < ADJ_STAGES; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[ADJ_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < ADJ_STAGES; s++) begin
        if (rdy[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // stage 1: input word
  elem_t [N_ELEM-1:0] e1_q;
  logic               m1_q;
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      e1_q <= in_elem_i;
      m1_q <= in_mode_i;
    end
  end

  // stage 2: element products
  prod_t              p2_d [N_PROD];
  prod_t              p2_q [N_PROD];
  elem_t [N_ELEM-1:0] e2_q;
  logic               m2_q;
  always_comb begin
    for (int j = 0; j < N_PROD; j++) begin
      p2_d[j] = $signed(e1_q[PROD_L[j]]) * $signed(e1_q[PROD_R[j]]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      p2_q <= p2_d;
      e2_q <= e1_q;
      m2_q <= m1_q;
    end
  end

  // stage 3: cofactors
  cof_t               c3_d [N_LIN];
  cof_t               c3_q [N_LIN];
  elem_t [N_ELEM-1:0] e3_q;
  logic               m3_q;
  always_comb begin
    for (int k = 0; k < N_LIN; k++) begin
      c3_d[k] = COF_W'(p2_q[2*k]) - COF_W'(p2_q[2*k+1]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      c3_q <= c3_d;
      e3_q <= e2_q;
      m3_q <= m2_q;
    end
  end

  // stage 4: partial products, cofactor split into low and high slices
  part_t              dlo4_d [N_AXIS];
  part_t              dhi4_d [N_AXIS];
  part_t              tlo4_d [N_LIN];
  part_t              thi4_d [N_LIN];
  part_t              dlo4_q [N_AXIS];
  part_t              dhi4_q [N_AXIS];
  part_t              tlo4_q [N_LIN];
  part_t              thi4_q [N_LIN];
  cof_t               c4_q   [N_LIN];
  elem_t [N_AXIS-1:0] t4_q;
  logic               m4_q;
  always_comb begin
    cof_t cs;
    for (int d = 0; d < N_AXIS; d++) begin
      cs        = c3_q[DET_COF[d]];
      dlo4_d[d] = $signed(e3_q[d]) * $signed({1'b0, cs[DATA_WIDTH-1:0]});
      dhi4_d[d] = $signed(e3_q[d]) * $signed(cs[COF_W-1:DATA_WIDTH]);
    end
    for (int r = 0; r < N_AXIS; r++) begin
      for (int c = 0; c < N_AXIS; c++) begin
        cs                  = c3_q[r + N_AXIS*c];
        tlo4_d[N_AXIS*r+c]  = $signed(e3_q[N_LIN+c]) * $signed({1'b0, cs[DATA_WIDTH-1:0]});
        thi4_d[N_AXIS*r+c]  = $signed(e3_q[N_LIN+c]) * $signed(cs[COF_W-1:DATA_WIDTH]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      dlo4_q <= dlo4_d;
      dhi4_q <= dhi4_d;
      tlo4_q <= tlo4_d;
      thi4_q <= thi4_d;
      c4_q   <= c3_q;
      t4_q   <= e3_q[N_ELEM-1:N_LIN];
      m4_q   <= m3_q;
    end
  end

  // stage 5: recombine slices into full products
  det_t               dp5_d [N_AXIS];
  det_t               tp5_d [N_LIN];
  det_t               dp5_q [N_AXIS];
  det_t               tp5_q [N_LIN];
  cof_t               c5_q  [N_LIN];
  elem_t [N_AXIS-1:0] t5_q;
  logic               m5_q;
  always_comb begin
    for (int d = 0; d < N_AXIS; d++) begin
      dp5_d[d] = (DET_W'(dhi4_q[d]) <<< DATA_WIDTH) + DET_W'(dlo4_q[d]);
    end
    for (int j = 0; j < N_LIN; j++) begin
      tp5_d[j] = (DET_W'(thi4_q[j]) <<< DATA_WIDTH) + DET_W'(tlo4_q[j]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      dp5_q <= dp5_d;
      tp5_q <= tp5_d;
      c5_q  <= c4_q;
      t5_q  <= t4_q;
      m5_q  <= m4_q;
    end
  end

  // stage 6: determinant and translation sums
  adj_word_t w6_d;
  adj_word_t w6_q;
  always_comb begin
    w6_d.mode = m5_q;
    w6_d.tr   = t5_q;
    for (int k = 0; k < N_LIN; k++) w6_d.cof[k] = c5_q[k];
    w6_d.det = dp5_q[0] + dp5_q[1] + dp5_q[2];
    for (int r = 0; r < N_AXIS; r++) begin
      w6_d.acc[r] = tp5_q[N_AXIS*r] + tp5_q[N_AXIS*r+1] + tp5_q[N_AXIS*r+2];
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[5]) w6_q <= w6_d;
  end

  assign out_word_o = w6_q;

endmodule

// File: design/ami_div.sv
// Twelve-lane pipelined divider: magnitudes, rounded dividend, then one
// restoring quotient bit per stage and saturation. Depends on ami_pkg.
module ami_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  ami_pkg::adj_word_t                    in_word_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output ami_pkg::elem_t [ami_pkg::N_ELEM-1:0]  out_res_o
);
  import ami_pkg::*;

  localparam int QW = DATA_WIDTH;

  logic [DIV_STAGES-1:0] v_q;
  logic [DIV_STAGES:0]   rdy;

  assign rdy[DIV_STAGES] = out_ready_i;
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_rdy
    assign rdy[s] = !v_q[s] || rdy[s+1];
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[DIV_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < DIV_STAGES; s++) begin
        if (rdy[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // stage P1: signs and magnitudes; a zero determinant becomes one LSB
  abs_t               dabs1_d, dabs1_q;
  abs_t               nabs1_d [N_ELEM];
  abs_t               nabs1_q [N_ELEM];
  logic [N_ELEM-1:0]  neg1_d, neg1_q;
  elem_t [N_AXIS-1:0] tr1_q;
  logic               m1_q;
  always_comb begin
    det_t dv;
    cof_t cs;
    det_t as;
    logic dneg;
    dv   = in_word_i.det;
    dneg = dv[DET_W-1];
    if (dv == '0) dabs1_d = ABS_W'(1);
    else if (dneg) dabs1_d = ABS_W'(-dv);
    else dabs1_d = ABS_W'(dv);
    for (int k = 0; k < N_LIN; k++) begin
      cs         = in_word_i.mode ? in_word_i.cof[TRANS_SRC[k]] : in_word_i.cof[k];
      neg1_d[k]  = cs[COF_W-1] ^ dneg;
      nabs1_d[k] = cs[COF_W-1] ? ABS_W'(-cs) : ABS_W'(cs);
    end
    // translation numerator is minus the sum
    for (int r = 0; r < N_AXIS; r++) begin
      as                 = in_word_i.acc[r];
      neg1_d[N_LIN+r]    = (!as[DET_W-1] && (as != '0)) ^ dneg;
      nabs1_d[N_LIN+r]   = as[DET_W-1] ? ABS_W'(-as) : ABS_W'(as);
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      dabs1_q <= dabs1_d;
      nabs1_q <= nabs1_d;
      neg1_q  <= neg1_d;
      tr1_q   <= in_word_i.tr;
      m1_q    <= in_word_i.mode;
    end
  end

  // stage P2: dividend 2|n|*2^sh + |d|, divisor 2|d|
  num_t               num2_d [N_ELEM];
  num_t               num2_q [N_ELEM];
  den_t               den2_q;
  logic [N_ELEM-1:0]  neg2_q;
  elem_t [N_AXIS-1:0] tr2_q;
  logic               m2_q;
  always_comb begin
    for (int k = 0; k < N_LIN; k++) begin
      num2_d[k] = (NUM_W'(nabs1_q[k]) << LIN_SH) + NUM_W'(dabs1_q);
    end
    for (int k = N_LIN; k < N_ELEM; k++) begin
      num2_d[k] = (NUM_W'(nabs1_q[k]) << TR_SH) + NUM_W'(dabs1_q);
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      num2_q <= num2_d;
      den2_q <= {dabs1_q, 1'b0};
      neg2_q <= neg1_q;
      tr2_q  <= tr1_q;
      m2_q   <= m1_q;
    end
  end

  // quotient stages: index 0 holds the overflow check, index i has i bits done
  den_t               br_q   [QW+1][N_ELEM];
  logic [QW-1:0]      bq_q   [QW+1][N_ELEM];
  logic [N_ELEM-1:0]  bovf_q [QW+1];
  logic [N_ELEM-1:0]  bneg_q [QW+1];
  den_t               bden_q [QW+1];
  elem_t [N_AXIS-1:0] btr_q  [QW+1];
  logic               bmode_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      for (int k = 0; k < N_ELEM; k++) begin
        br_q[0][k]   <= DEN_W'(num2_q[k][NUM_W-1:QW]);
        bq_q[0][k]   <= num2_q[k][QW-1:0];
        bovf_q[0][k] <= DEN_W'(num2_q[k][NUM_W-1:QW]) >= den2_q;
      end
      bneg_q[0]  <= neg2_q;
      bden_q[0]  <= den2_q;
      btr_q[0]   <= tr2_q;
      bmode_q[0] <= m2_q;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_bit
    logic [DEN_W:0] rt [N_ELEM];
    logic [DEN_W:0] df [N_ELEM];
    den_t           r_d [N_ELEM];
    logic [QW-1:0]  q_d [N_ELEM];
    always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
        rt[k] = {br_q[i-1][k], bq_q[i-1][k][QW-1]};
        df[k] = rt[k] - {1'b0, bden_q[i-1]};
        if (rt[k] >= {1'b0, bden_q[i-1]}) begin
          r_d[k] = df[k][DEN_W-1:0];
          q_d[k] = {bq_q[i-1][k][QW-2:0], 1'b1};
        end else begin
          r_d[k] = rt[k][DEN_W-1:0];
          q_d[k] = {bq_q[i-1][k][QW-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[2+i]) begin
        br_q[i]    <= r_d;
        bq_q[i]    <= q_d;
        bovf_q[i]  <= bovf_q[i-1];
        bneg_q[i]  <= bneg_q[i-1];
        bden_q[i]  <= bden_q[i-1];
        btr_q[i]   <= btr_q[i-1];
        bmode_q[i] <= bmode_q[i-1];
      end
    end
  end

  // final stage: apply sign, saturate, pass translation through in mode 1
  elem_t [N_ELEM-1:0] res_d, res_q;
  always_comb begin
    logic [QW-1:0] q;
    logic          ovf;
    logic          neg;
    for (int k = 0; k < N_ELEM; k++) begin
      q   = bq_q[QW][k];
      ovf = bovf_q[QW][k];
      neg = bneg_q[QW][k];
      if (neg) begin
        if (ovf || (q[QW-1] && (q[QW-2:0] != '0))) res_d[k] = NEG_MIN;
        else res_d[k] = elem_t'(-q);
      end else begin
        if (ovf || q[QW-1]) res_d[k] = POS_MAX;
        else res_d[k] = elem_t'(q);
      end
    end
    if (bmode_q[QW]) begin
      for (int r = 0; r < N_AXIS; r++) res_d[N_LIN+r] = btr_q[QW][r];
    end
  end
  always_ff @(posedge clk_i) begin
    if (rdy[DIV_STAGES-1]) res_q <= res_d;
  end

  assign out_res_o = res_q;

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> bden_q[0] != '0)
    else $error("divisor is zero after determinant fix-up");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[QW+2] && !bovf_q[QW][0]) |-> br_q[QW][0] < bden_q[QW])
    else $error("partial remainder reached the divisor");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v_q[0])
    else $error("accepted word did not enter the divider");

endmodule

// File: design/affine_matrix_inverse_top.sv
// Affine 3x4 matrix inverse in Q16.16: adjugate pipeline plus divider.
// Throughput: one matrix per cycle without stalls; six adjugate stages
// and 36 divider stages, 32 of them one quotient bit each, set the depth.
// Reset clears every valid bit and sets the mode register to full inverse.
// Depends on ami_pkg, ami_if, ami_adj and ami_div.
module affine_matrix_inverse_top (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  logic   cfg_wdata_i,
  ami_in_if.sink    in_ch,
  ami_out_if.source out_ch
);
  import ami_pkg::*;

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  elem_t [N_ELEM-1:0] elem;
  elem_t [N_ELEM-1:0] res;
  adj_word_t          adj_word;
  logic               adj_valid;
  logic               adj_ready;

  assign elem[0]  = in_ch.data.elem_0;
  assign elem[1]  = in_ch.data.elem_1;
  assign elem[2]  = in_ch.data.elem_2;
  assign elem[3]  = in_ch.data.elem_3;
  assign elem[4]  = in_ch.data.elem_4;
  assign elem[5]  = in_ch.data.elem_5;
  assign elem[6]  = in_ch.data.elem_6;
  assign elem[7]  = in_ch.data.elem_7;
  assign elem[8]  = in_ch.data.elem_8;
  assign elem[9]  = in_ch.data.elem_9;
  assign elem[10] = in_ch.data.elem_10;
  assign elem[11] = in_ch.data.elem_11;

  ami_adj u_adj (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_elem_i   (elem),
    .in_mode_i   (mode_q),
    .out_valid_o (adj_valid),
    .out_ready_i (adj_ready),
    .out_word_o  (adj_word)
  );

  ami_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (adj_valid),
    .in_ready_o  (adj_ready),
    .in_word_i   (adj_word),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_res_o   (res)
  );

  assign out_ch.data.res_0  = res[0];
  assign out_ch.data.res_1  = res[1];
  assign out_ch.data.res_2  = res[2];
  assign out_ch.data.res_3  = res[3];
  assign out_ch.data.res_4  = res[4];
  assign out_ch.data.res_5  = res[5];
  assign out_ch.data.res_6  = res[6];
  assign out_ch.data.res_7  = res[7];
  assign out_ch.data.res_8  = res[8];
  assign out_ch.data.res_9  = res[9];
  assign out_ch.data.res_10 = res[10];
  assign out_ch.data.res_11 = res[11];

endmodule

// File: tb/sv/tb_top.sv
// Testbench for affine_matrix_inverse_top: directed table, then random matrices,
// every result checked against a table value or a wide-integer inverse predictor.
// Depends on ami_pkg, ami_if and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ami_pkg::*;

  localparam int WATCHDOG = 4000;
  localparam int N_RANDOM = 730;
  localparam int DRAIN    = 60;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    in_word_t  m;
    logic      chk;
    out_word_t res;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_wdata_i = 1'b0;
  logic mode_q = 1'b0;
  int   errors = 0;
  int   idle_cycles = 0;
  out_word_t inverse_q[$];

  ami_in_if  in_ch ();
  ami_out_if out_ch ();

  affine_matrix_inverse_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
  end

  // round(num * 2^sh / den), ties away from zero, saturated to 32 bits
  function automatic elem_t ratio_q16(wide_t num, int sh, wide_t den);
    wide_t n, d, q;
    logic neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = ((n <<< (sh + 1)) + d) / (d <<< 1);
    if (neg) return (q > 256'sd2147483648) ? NEG_MIN : elem_t'(-q);
    return (q > 256'sd2147483647) ? POS_MAX : elem_t'(q);
  endfunction

  function automatic out_word_t invert_affine(in_word_t m, logic mode);
    elem_t     e[12];
    wide_t     w[12];
    wide_t     cof[9];
    wide_t     det, acc;
    elem_t     r[12];
    out_word_t o;
    e = '{m.elem_0, m.elem_1, m.elem_2, m.elem_3, m.elem_4, m.elem_5,
          m.elem_6, m.elem_7, m.elem_8, m.elem_9, m.elem_10, m.elem_11};
    foreach (e[k]) w[k] = wide_t'(e[k]);
    // w[3c+r] is column c, row r
    cof[0] = w[4]*w[8] - w[5]*w[7];
    cof[1] = w[2]*w[7] - w[1]*w[8];
    cof[2] = w[1]*w[5] - w[2]*w[4];
    cof[3] = w[5]*w[6] - w[3]*w[8];
    cof[4] = w[0]*w[8] - w[2]*w[6];
    cof[5] = w[3]*w[2] - w[0]*w[5];
    cof[6] = w[3]*w[7] - w[6]*w[4];
    cof[7] = w[6]*w[1] - w[0]*w[7];
    cof[8] = w[0]*w[4] - w[3]*w[1];
    det = w[0]*cof[0] + w[1]*cof[3] + w[2]*cof[6];
    if (det == 0) det = 1;
    for (int k = 0; k < 9; k++)
      r[k] = ratio_q16(mode ? cof[3*(k%3) + k/3] : cof[k], 2*FRAC_BITS, det);
    for (int a = 0; a < 3; a++) begin
      acc = 0;
      for (int c = 0; c < 3; c++) acc += cof[a + 3*c] * w[9 + c];
      r[9 + a] = mode ? e[9 + a] : ratio_q16(-acc, FRAC_BITS, det);
    end
    o = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8], r[9], r[10], r[11]};
    return o;
  endfunction

  function automatic elem_t rand_elem(int kind);
    case (kind)
      0: return elem_t'($urandom);
      1: return elem_t'($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      2: return elem_t'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: return elem_t'($urandom_range(0, 8)) - 32'sh4;
    endcase
  endfunction

  function automatic in_word_t rand_matrix();
    in_word_t m;
    int kind;
    kind = $urandom_range(0, 9);
    kind = (kind < 5) ? 1 : (kind < 7) ? 2 : (kind < 9) ? 0 : 3;
    m = {rand_elem(kind), rand_elem(kind), rand_elem(kind), rand_elem(kind),
         rand_elem(kind), rand_elem(kind), rand_elem(kind), rand_elem(kind),
         rand_elem(kind), rand_elem(0), rand_elem(kind), rand_elem(2)};
    // occasionally force a singular matrix: column 1 equals column 0
    if ($urandom_range(0, 9) == 0) begin
      m.elem_3 = m.elem_0;
      m.elem_4 = m.elem_1;
      m.elem_5 = m.elem_2;
    end
    return m;
  endfunction

  // valid stays high into the next word when there is no gap
  task automatic send_matrix(in_word_t m);
    int gap;
    gap = $urandom_range(0, 19);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    inverse_q.push_back(invert_affine(m, mode_q));
    in_ch.valid <= 1'b1;
    in_ch.data  <= m;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic write_mode(logic v);
    in_ch.valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = v;
  endtask

  // receiver: random stall per word, check against the oldest expectation
  initial begin
    out_word_t want;
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 19);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $realtime, out_ch.data);
        errors++;
      end else begin
        want = inverse_q.pop_front();
        if (out_ch.data !== want) begin
          $display("%0t: mismatch, expected %h, actual %h", $realtime, want, out_ch.data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("affine_matrix_inverse_top verification failed");
      $finish;
    end
  end

  initial begin
    vec_t table_v[$];
    vec_t v;
    elem_t one;
    one = 32'sh0001_0000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // identity with zero translation inverts to itself
    v.m = {one, 32'sd0, 32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, one,
           32'sd0, 32'sd0, 32'sd0};
    v.chk = 1'b1; v.res = out_word_t'(v.m); table_v.push_back(v);
    // all zero: singular, zero cofactors give zero
    v.m = '0; v.chk = 1'b1; v.res = '0; table_v.push_back(v);
    // identity with translation: negated translation
    v.m = {one, 32'sd0, 32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, one,
           32'sh0003_0000, -32'sh0002_8000, POS_MAX};
    v.chk = 1'b1;
    v.res = {one, 32'sd0, 32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, one,
             -32'sh0003_0000, 32'sh0002_8000, -POS_MAX};
    table_v.push_back(v);
    v.chk = 1'b0;
    v.m = {12{POS_MAX}}; table_v.push_back(v);
    v.m = {12{NEG_MIN}}; table_v.push_back(v);
    v.m = {12{32'sh1}}; table_v.push_back(v);
    v.m = {12{-32'sh1}}; table_v.push_back(v);
    v.m = {NEG_MIN, 32'sd0, 32'sd0, 32'sd0, POS_MAX, 32'sd0, 32'sd0, 32'sd0, NEG_MIN,
           NEG_MIN, POS_MAX, NEG_MIN};
    table_v.push_back(v);
    // negative determinant
    v.m = {-one, 32'sd0, 32'sd0, 32'sd0, one, 32'sd0, 32'sd0, 32'sd0, one,
           one, one, one};
    table_v.push_back(v);
    // singular with nonzero cofactors: saturates
    v.m = {one, one, 32'sd0, one, one, 32'sd0, 32'sd0, 32'sd0, one,
           32'sd5, 32'sd0, 32'sd0};
    table_v.push_back(v);
    // rounding: 1/3 and tiny scale
    v.m = {32'sh0003_0000, 32'sd0, 32'sd0, 32'sd0, 32'sh0003_0000, 32'sd0,
           32'sd0, 32'sd0, 32'sh0003_0000, 32'sd1, -32'sd1, 32'sd3};
    table_v.push_back(v);
    v.m = {32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1,
           32'sd1, 32'sd1, 32'sd1};
    table_v.push_back(v);

    for (int p = 0; p < 2; p++) begin
      if (p == 1) write_mode(1'b1);
      foreach (table_v[i]) begin
        send_matrix(table_v[i].m);
        if (table_v[i].chk && p == 0) inverse_q[$] = table_v[i].res;
      end
    end
    write_mode(1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) write_mode(1'b1);
      if (i == 2 * N_RANDOM / 3) write_mode(1'b0);
      send_matrix(rand_matrix());
    end
    in_ch.valid <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (errors == 0) $display("affine_matrix_inverse_top verification clean");
    else $display("affine_matrix_inverse_top verification failed");
    $finish;
  end
endmodule
